@@ rtl/tpdl_pkg.sv @@
// Shared types, codes and constants of the two-way packet delay line.
`default_nettype none

package tpdl_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 32;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int HANDLE_W        = 16;
  localparam int STAMP_W         = 32;
  localparam int DELAY_W         = 16;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SEND_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECV_DELAY = 2'd1;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] DIR_SEND = 2'd0;
  localparam logic [1:0] DIR_RECV = 2'd1;

  localparam logic PATH_DOWN = 1'b0;
  localparam logic PATH_UP   = 1'b1;

  localparam logic [1:0] ST_FWD     = 2'd0;
  localparam logic [1:0] ST_BAD_DIR = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic                operation;
    logic                packet_present;
    logic [HANDLE_W-1:0] packet_handle;
    logic [1:0]          direction;
  } pkt_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] packet_handle_res;
    logic                path;
    logic [1:0]          status;
    logic                last;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHK_SEND,
    S_CHK_RECV
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic pop_send;
    logic pop_recv;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic out_free;
    logic send_due;
    logic recv_due;
    logic pend_valid;
    logic at_limit;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/tpdl_ctrl.sv @@
// Controller state machine: accepts beats and walks both queue heads on a tick.
`default_nettype none

module tpdl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pkt_valid,
  input  tpdl_pkg::dp_status_t   status,
  output logic                   pkt_ready,
  output tpdl_pkg::dp_cmd_t      cmd
);
  import tpdl_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A release moves the pending result out, so it needs the output free
  // only when something is pending.
  always_comb begin
    state_next = state;
    cmd        = '0;
    pkt_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        pkt_ready = status.out_free;
        if (pkt_valid && status.out_free) begin
          cmd.accept = 1'b1;
          if (status.is_tick) begin
            state_next = S_CHK_SEND;
          end
        end
      end
      S_CHK_SEND: begin
        if (status.send_due && !status.at_limit) begin
          cmd.pop_send = !status.pend_valid || status.out_free;
        end else begin
          state_next = S_CHK_RECV;
        end
      end
      S_CHK_RECV: begin
        if (status.recv_due && !status.at_limit) begin
          cmd.pop_recv = !status.pend_valid || status.out_free;
        end else if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tpdl_fifo.sv @@
// One direction's descriptor queue: handle and stamp memory with head and count.
`default_nettype none

module tpdl_fifo #(
  parameter int DEPTH = tpdl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [tpdl_pkg::HANDLE_W-1:0] push_handle,
  input  logic [tpdl_pkg::STAMP_W-1:0]  push_stamp,
  input  logic                          pop,
  output logic                          full,
  output logic                          empty,
  output logic [tpdl_pkg::HANDLE_W-1:0] head_handle,
  output logic [tpdl_pkg::STAMP_W-1:0]  head_stamp
);
  import tpdl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [HANDLE_W-1:0] handles [DEPTH];
  logic [STAMP_W-1:0]  stamps  [DEPTH];

  logic [AW-1:0] head, head_next, tail;
  logic [CW-1:0] count;
  logic [SW-1:0] tail_sum;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    head_next = head;
    if (pop) begin
      head_next = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
    end
    tail_sum = SW'(head) + SW'(count);
    if (tail_sum >= SW'(DEPTH)) begin
      tail = AW'(tail_sum - SW'(DEPTH));
    end else begin
      tail = AW'(tail_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // The read follows the next head, so the data is current in the cycle after a pop.
  always_ff @(posedge clk) begin
    if (push) begin
      handles[tail] <= push_handle;
      stamps[tail]  <= push_stamp;
    end
    head_handle <= handles[head_next];
    head_stamp  <= stamps[head_next];
  end

endmodule

`default_nettype wire

@@ rtl/tpdl_dp.sv @@
// Datapath: tick counter, delay registers, both queues, pending and output registers.
`default_nettype none

module tpdl_dp #(
  parameter int QUEUE_DEPTH = tpdl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tpdl_pkg::pkt_t                 pkt,
  input  logic                           cfg_we,
  input  logic [tpdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpdl_pkg::DELAY_W-1:0]   cfg_data,
  input  tpdl_pkg::dp_cmd_t              cmd,
  input  logic                           res_ready,
  output tpdl_pkg::dp_status_t           status,
  output logic                           res_valid,
  output tpdl_pkg::res_t                 res
);
  import tpdl_pkg::*;

  logic [STAMP_W-1:0]   now_ticks;
  logic [DELAY_W-1:0]   send_delay, receive_delay;
  logic [RES_CNT_W-1:0] n_results;
  logic                 pend_valid;
  res_t                 pend;

  logic                send_full, send_empty, recv_full, recv_empty;
  logic [HANDLE_W-1:0] send_head_handle, recv_head_handle;
  logic [STAMP_W-1:0]  send_head_stamp, recv_head_stamp;
  logic [STAMP_W-1:0]  send_elapsed, recv_elapsed;

  logic is_arrival, push_send, push_recv, arr_has_res, pop_any;
  res_t arr_res;

  assign is_arrival = cmd.accept && (pkt.operation == OP_ARRIVE) && pkt.packet_present;
  assign pop_any    = cmd.pop_send || cmd.pop_recv;

  always_comb begin
    push_send       = 1'b0;
    push_recv       = 1'b0;
    arr_res.packet_handle_res = pkt.packet_handle;
    arr_res.path    = PATH_DOWN;
    arr_res.status  = ST_FWD;
    arr_res.last    = 1'b1;
    if (pkt.direction == DIR_SEND) begin
      if (send_delay == '0) begin
        arr_res.path = PATH_DOWN;
      end else if (send_full) begin
        arr_res.status = ST_FULL;
      end else begin
        push_send = is_arrival;
      end
    end else if (pkt.direction == DIR_RECV) begin
      if (receive_delay == '0) begin
        arr_res.path = PATH_UP;
      end else if (recv_full) begin
        arr_res.status = ST_FULL;
      end else begin
        push_recv = is_arrival;
      end
    end else begin
      arr_res.status = ST_BAD_DIR;
    end
    arr_has_res = is_arrival && !push_send && !push_recv;
  end

  // Elapsed time is taken modulo the counter width, so a wrap is harmless.
  assign send_elapsed = now_ticks - send_head_stamp;
  assign recv_elapsed = now_ticks - recv_head_stamp;

  assign status.is_tick    = (pkt.operation == OP_TICK);
  assign status.out_free   = !res_valid || res_ready;
  assign status.send_due   = !send_empty &&
                             (send_elapsed >= {{(STAMP_W-DELAY_W){1'b0}}, send_delay});
  assign status.recv_due   = !recv_empty &&
                             (recv_elapsed >= {{(STAMP_W-DELAY_W){1'b0}}, receive_delay});
  assign status.pend_valid = pend_valid;
  assign status.at_limit   = (n_results == RES_CNT_W'(MAX_RESULTS));

  tpdl_fifo #(.DEPTH(QUEUE_DEPTH)) u_send_q (
    .clk         (clk),
    .rst         (rst),
    .push        (push_send),
    .push_handle (pkt.packet_handle),
    .push_stamp  (now_ticks),
    .pop         (cmd.pop_send),
    .full        (send_full),
    .empty       (send_empty),
    .head_handle (send_head_handle),
    .head_stamp  (send_head_stamp)
  );

  tpdl_fifo #(.DEPTH(QUEUE_DEPTH)) u_recv_q (
    .clk         (clk),
    .rst         (rst),
    .push        (push_recv),
    .push_handle (pkt.packet_handle),
    .push_stamp  (now_ticks),
    .pop         (cmd.pop_recv),
    .full        (recv_full),
    .empty       (recv_empty),
    .head_handle (recv_head_handle),
    .head_stamp  (recv_head_stamp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks     <= '0;
      send_delay    <= '0;
      receive_delay <= '0;
      n_results     <= '0;
      pend_valid    <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (arr_has_res || cmd.flush || (pop_any && pend_valid)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_index == REG_SEND_DELAY) begin
          send_delay <= cfg_data;
        end else if (cfg_index == REG_RECV_DELAY) begin
          receive_delay <= cfg_data;
        end
      end
      if (cmd.accept && status.is_tick) begin
        now_ticks <= now_ticks + STAMP_W'(1);
        n_results <= '0;
      end
      if (pop_any) begin
        pend_valid <= 1'b1;
        n_results  <= n_results + RES_CNT_W'(1);
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // A release waits in the pending register until it is known whether another follows.
  always_ff @(posedge clk) begin
    if (arr_has_res) begin
      res <= arr_res;
    end else if (cmd.flush) begin
      res <= '{packet_handle_res: pend.packet_handle_res, path: pend.path,
               status: pend.status, last: 1'b1};
    end else if (pop_any && pend_valid) begin
      res <= pend;
    end
    if (pop_any) begin
      pend <= '{packet_handle_res: cmd.pop_send ? send_head_handle : recv_head_handle,
                path: cmd.pop_send ? PATH_DOWN : PATH_UP,
                status: ST_FWD, last: 1'b0};
    end
  end

endmodule

`default_nettype wire

@@ rtl/two_way_packet_delay_line_top.sv @@
// Top level of the two-way packet delay line: controller plus datapath.
//
// Beats on the pkt channel are either an arrival (operation 0) or a tick
// (operation 1). An arrival with a valid descriptor is stamped with the current
// tick count and queued for its direction, or forwarded at once when that
// direction's delay is zero. A bad direction or a full queue drops the
// descriptor with a status. A tick advances time by one and then releases,
// send queue first, every descriptor whose elapsed ticks reach its delay, at
// most 32 per tick. The final result beat caused by one pkt beat carries last.
//
// An arrival is accepted in the idle state and its result sits in the output
// register in the next cycle, so arrivals can go back to back while the output
// register is free. A tick takes the accept, then one check of each queue head
// and one more per release; a full output register can hold the walk. Releases
// pass through a pending register and each leaves at the next release or flush.
//
// Reset clears the tick count, both queues and both delays at once. While a
// result stalls, the output register holds it, pkt_ready is low and at most one
// more release enters the pending register before the walk stops. The user
// writes the delays on the cfg port while the block is idle; nothing checks it.
`default_nettype none

module two_way_packet_delay_line_top #(
  parameter int QUEUE_DEPTH = tpdl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pkt_valid,
  output logic                           pkt_ready,
  input  tpdl_pkg::pkt_t                 pkt,
  output logic                           res_valid,
  input  logic                           res_ready,
  output tpdl_pkg::res_t                 res,
  input  logic                           cfg_we,
  input  logic [tpdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpdl_pkg::DELAY_W-1:0]   cfg_data
);
  import tpdl_pkg::*;

  // Commands from the controller and status from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  tpdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .status    (status),
    .pkt_ready (pkt_ready),
    .cmd       (cmd)
  );

  tpdl_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .res_ready (res_ready),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

`default_nettype wire

@@ rtl/tpdl_checker.sv @@
// Port-level assertions for the delay line and the bind that attaches them.
`default_nettype none

module tpdl_checker (
  input logic           clk,
  input logic           rst,
  input logic           pkt_valid,
  input logic           pkt_ready,
  input tpdl_pkg::pkt_t pkt,
  input logic           res_valid,
  input logic           res_ready,
  input tpdl_pkg::res_t res
);
  import tpdl_pkg::*;

  logic arrival_acc;
  assign arrival_acc = pkt_valid && pkt_ready && (pkt.operation == OP_ARRIVE);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  a_absent_silent: assert property (@(posedge clk) disable iff (rst)
    arrival_acc && !pkt.packet_present && !(res_valid && !res_ready) |=> !res_valid)
    else $error("absent packet produced a result");

  a_bad_dir_drop: assert property (@(posedge clk) disable iff (rst)
    arrival_acc && pkt.packet_present && pkt.direction[1]
    |=> res_valid && (res.status == ST_BAD_DIR) && res.last && (res.path == PATH_DOWN))
    else $error("bad direction not dropped at once");

endmodule

bind two_way_packet_delay_line_top tpdl_checker u_tpdl_checker (.*);

`default_nettype wire

@@ bench/two_way_packet_delay_line_top_test.sv @@
// Self-checking testbench of the two-way packet delay line: random and directed beats, scoreboard.
module two_way_packet_delay_line_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tpdl_pkg::*;

  // Sizes and knobs of the run.
  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int IDLE_PCT    = 17;      // chance in a hundred that a side idles
  localparam int HOLD_CYCLES = 300;     // long back-pressure stretch on the result side
  localparam int SETTLE_GAP  = 12;      // a tick with nothing due still keeps the block busy
  localparam int CYCLE_LIMIT = 150000;

  // Codes that the package does not name: the two invalid directions and the
  // two register indexes that the block has to ignore.
  localparam logic [1:0] DIR_BAD_LO = 2'd2;
  localparam logic [1:0] DIR_BAD_HI = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // One descriptor waiting in a direction's queue, with the tick it came in.
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } held_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pkt_valid = 1'b0;
  logic                 pkt_ready;
  pkt_t                 pkt = '0;
  logic                 res_valid;
  logic                 res_ready = 1'b0;
  res_t                 res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0]   cfg_data = '0;

  // Beats waiting to be offered, and the results that the accepted beats owe.
  pkt_t feed[$];
  res_t awaited[$];

  // Our own picture of the block: tick count, the two queues and the delays.
  logic [STAMP_W-1:0] tick_now = '0;
  held_t              send_held[$];
  held_t              recv_held[$];
  logic [DELAY_W-1:0] delay_send = '0;
  logic [DELAY_W-1:0] delay_recv = '0;

  int  mismatches = 0;
  int  cycle = 0;
  bit  calm = 1'b0;        // when set, neither side idles
  bit  want_hold = 1'b0;   // asks the result side for its long hold-off
  bit  hold_taken = 1'b0;
  int  hold_left = 0;

  two_way_packet_delay_line_top #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .pkt_valid(pkt_valid),
    .pkt_ready(pkt_ready),
    .pkt      (pkt),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // The run is bounded whatever the block does; a hang counts as a failure.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
    mismatches++;
  endtask

  // Appends a result to the list of results still owed.
  task automatic owe(input res_t r);
    awaited.insert(awaited.size(), r);
  endtask

  // Appends a beat to the list of beats waiting to be offered.
  task automatic offer(input pkt_t p);
    feed.insert(feed.size(), p);
  endtask

  function automatic res_t outcome(input logic [HANDLE_W-1:0] handle, input logic path,
                                   input logic [1:0] status);
    res_t r;
    r.packet_handle_res = handle;
    r.path              = path;
    r.status            = status;
    r.last              = 1'b0;
    return r;
  endfunction

  // Works out what one accepted beat does to the delay line and queues the
  // results it owes, in the order the block must send them. A tick walks the
  // send queue first, then the receive queue, and the elapsed time is taken
  // modulo 2^32 so a wrapping counter is harmless.
  task automatic predict_beat(input pkt_t p);
    int                 owed;
    logic [STAMP_W-1:0] gap;
    owed = 0;
    if (p.operation == OP_TICK) begin
      tick_now = tick_now + 1;
      while (send_held.size() > 0 && owed < MAX_RESULTS) begin
        gap = tick_now - send_held[0].stamp;
        if (gap < {16'd0, delay_send})
          break;
        owe(outcome(send_held[0].handle, PATH_DOWN, ST_FWD));
        void'(send_held.pop_front());
        owed++;
      end
      while (recv_held.size() > 0 && owed < MAX_RESULTS) begin
        gap = tick_now - recv_held[0].stamp;
        if (gap < {16'd0, delay_recv})
          break;
        owe(outcome(recv_held[0].handle, PATH_UP, ST_FWD));
        void'(recv_held.pop_front());
        owed++;
      end
    end else if (p.packet_present) begin
      if (p.direction != DIR_SEND && p.direction != DIR_RECV) begin
        owe(outcome(p.packet_handle, PATH_DOWN, ST_BAD_DIR));
        owed = 1;
      end else if (p.direction == DIR_SEND) begin
        // A zero delay forwards at once, even past descriptors still queued.
        if (delay_send == '0) begin
          owe(outcome(p.packet_handle, PATH_DOWN, ST_FWD));
          owed = 1;
        end else if (send_held.size() >= DEPTH) begin
          owe(outcome(p.packet_handle, PATH_DOWN, ST_FULL));
          owed = 1;
        end else begin
          send_held.insert(send_held.size(),
                           held_t'{handle: p.packet_handle, stamp: tick_now});
        end
      end else begin
        if (delay_recv == '0) begin
          owe(outcome(p.packet_handle, PATH_UP, ST_FWD));
          owed = 1;
        end else if (recv_held.size() >= DEPTH) begin
          owe(outcome(p.packet_handle, PATH_DOWN, ST_FULL));
          owed = 1;
        end else begin
          recv_held.insert(recv_held.size(),
                           held_t'{handle: p.packet_handle, stamp: tick_now});
        end
      end
    end
    // The final result caused by this beat carries the last flag.
    if (owed > 0)
      awaited[awaited.size() - 1].last = 1'b1;
  endtask

  // Driver: offers the pending beats. A beat that has been offered is held,
  // unchanged, until the block takes it; only then may the line go idle.
  always @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else begin
      if (pkt_valid && pkt_ready)
        predict_beat(pkt);
      if (!pkt_valid || pkt_ready) begin
        if (feed.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          pkt_valid <= 1'b1;
          pkt <= feed.pop_front();
        end else begin
          pkt_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off that lets the block
  // fill up and push back on its input while the driver keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_taken) begin
      res_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: every accepted result beat is held against the oldest result
  // still owed, field by field.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (awaited.size() == 0) begin
        report_mismatch("result beat with nothing owed, handle", res.packet_handle_res, 0);
      end else begin
        if (res.packet_handle_res != awaited[0].packet_handle_res)
          report_mismatch("packet_handle_res", res.packet_handle_res,
                          awaited[0].packet_handle_res);
        if (res.path != awaited[0].path)
          report_mismatch("path", res.path, awaited[0].path);
        if (res.status != awaited[0].status)
          report_mismatch("status", res.status, awaited[0].status);
        if (res.last != awaited[0].last)
          report_mismatch("last", res.last, awaited[0].last);
        void'(awaited.pop_front());
      end
    end
  end

  function automatic pkt_t arrival(input logic [1:0] dir, input logic [HANDLE_W-1:0] handle);
    pkt_t p;
    p.operation      = OP_ARRIVE;
    p.packet_present = 1'b1;
    p.packet_handle  = handle;
    p.direction      = dir;
    return p;
  endfunction

  // A tick carries random junk in its other fields; the block must ignore it.
  function automatic pkt_t tick_beat();
    logic [31:0] bits;
    pkt_t        p;
    bits        = $urandom;
    p           = bits[$bits(pkt_t)-1:0];
    p.operation = OP_TICK;
    return p;
  endfunction

  // Queues a run of random beats. Arrivals with no descriptor are sprinkled
  // in but do not count toward the run, since the block simply drops them.
  task automatic offer_random(input int beats, input int tick_pct, input int send_pct);
    int          counted;
    logic [31:0] bits;
    pkt_t        p;
    counted = 0;
    while (counted < beats) begin
      if ($urandom_range(99) < tick_pct) begin
        p = tick_beat();
      end else begin
        bits = $urandom;
        p = bits[$bits(pkt_t)-1:0];
        p.operation = OP_ARRIVE;
        p.packet_present = ($urandom_range(99) >= 6);
        if ($urandom_range(99) < 8)
          p.direction = $urandom_range(1) ? DIR_BAD_HI : DIR_BAD_LO;
        else
          p.direction = ($urandom_range(99) < send_pct) ? DIR_SEND : DIR_RECV;
      end
      if (p.operation == OP_TICK || p.packet_present)
        counted++;
      offer(p);
    end
  endtask

  // Waits until every beat is taken and every owed result has come back,
  // then a little longer in case the last beat was a tick that released
  // nothing and the block is still walking its queues.
  task automatic settle();
    do @(negedge clk); while (feed.size() != 0 || pkt_valid || awaited.size() != 0);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  // Register writes only happen while the block is idle, so the delay in our
  // picture of the block can change at the same moment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEND_DELAY)
      delay_send = val;
    else if (idx == REG_RECV_DELAY)
      delay_recv = val;
  endtask

  initial begin
    pkt_t gone;
    int   i;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Both delays are zero after reset: everything valid passes straight
    // through. Also the handle extremes, both invalid directions, an empty
    // arrival and a tick with nothing queued.
    offer(arrival(DIR_SEND, 16'h0000));
    offer(arrival(DIR_RECV, 16'hFFFF));
    offer(arrival(DIR_BAD_LO, 16'h5A5A));
    offer(arrival(DIR_BAD_HI, 16'hFFFF));
    gone = arrival(DIR_SEND, 16'hA5A5);
    gone.packet_present = 1'b0;
    offer(gone);
    offer(tick_beat());
    settle();

    // Pass-through traffic while the result side holds off for a long time,
    // so the output register stays full and the input stalls.
    want_hold = 1'b1;
    offer_random(40, 0, 50);
    settle();

    // Short delays: queued arrivals, a tick that frees only the receive side,
    // one that frees three send beats at once, and one with nothing due.
    write_reg(REG_SEND_DELAY, 16'd2);
    write_reg(REG_RECV_DELAY, 16'd1);
    @(negedge clk);
    offer(arrival(DIR_SEND, $urandom_range(16'hFFFF)));
    offer(arrival(DIR_SEND, $urandom_range(16'hFFFF)));
    offer(arrival(DIR_RECV, $urandom_range(16'hFFFF)));
    offer(arrival(DIR_SEND, $urandom_range(16'hFFFF)));
    offer(tick_beat());
    offer(tick_beat());
    offer(tick_beat());
    settle();
    offer_random(50, 35, 50);
    settle();

    // Longest delays: nothing leaves, both queues fill and overflow into
    // full-queue drops. Whatever was left over from the last run waits too.
    write_reg(REG_SEND_DELAY, 16'hFFFF);
    write_reg(REG_RECV_DELAY, 16'hFFFF);
    @(negedge clk);
    for (i = 0; i < 20; i++) begin
      offer(arrival(DIR_SEND, $urandom_range(16'hFFFF)));
      offer(arrival(DIR_RECV, $urandom_range(16'hFFFF)));
      if (i % 6 == 5)
        offer(arrival($urandom_range(1) ? DIR_BAD_HI : DIR_BAD_LO,
                      $urandom_range(16'hFFFF)));
    end
    offer(tick_beat());
    offer(tick_beat());
    settle();

    // Both delays dropped to zero with full queues: a new send arrival passes
    // the queued ones, and the next tick empties both queues in one go, right
    // at the per-tick result limit.
    write_reg(REG_SEND_DELAY, 16'd0);
    write_reg(REG_RECV_DELAY, 16'd0);
    @(negedge clk);
    offer(arrival(DIR_SEND, $urandom_range(16'hFFFF)));
    offer(arrival(DIR_RECV, $urandom_range(16'hFFFF)));
    offer(tick_beat());
    settle();

    // A stretch with no idling on either side.
    write_reg(REG_SEND_DELAY, 16'd3);
    write_reg(REG_RECV_DELAY, 16'd0);
    @(negedge clk);
    calm = 1'b1;
    offer_random(60, 40, 60);
    settle();
    calm = 1'b0;

    // Delays change under packets still queued; the spare register indexes
    // are written with junk and must change nothing.
    write_reg(REG_SEND_DELAY, 16'd0);
    write_reg(REG_RECV_DELAY, 16'd5);
    write_reg(REG_SPARE_LO, $urandom_range(16'hFFFF));
    write_reg(REG_SPARE_HI, $urandom_range(16'hFFFF));
    @(negedge clk);
    offer_random(50, 40, 40);
    settle();

    // Give any stray result a last chance to show up before the verdict.
    repeat (40) @(negedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tpdl_pkg.sv
rtl/tpdl_ctrl.sv
rtl/tpdl_fifo.sv
rtl/tpdl_dp.sv
rtl/two_way_packet_delay_line_top.sv
rtl/tpdl_checker.sv
bench/two_way_packet_delay_line_top_test.sv
